[rtl/vms_pkg.sv]
// ----------------------------------------------------------------------------
// vms_pkg: shared types and constants for the von Mises stress core
// Mode codes, radicand and root widths, and the record that travels
// from one square-root cell to the next.
// ----------------------------------------------------------------------------
package vms_pkg;

   localparam int RadW  = 68;  // radicand width, exact at 2*frac fraction bits
   localparam int RootW = 34;  // root width, one bit per cell
   localparam int OutW  = 33;

   typedef enum logic [1:0] {
      MODE_NONE  = 2'd0,
      MODE_PLANE = 2'd1,
      MODE_SOLID = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   // One stage of the digit-by-digit root: remainder and partial root.
   typedef struct packed {
      logic             vld;
      logic [RadW-1:0]  rem;
      logic [RadW-1:0]  rad;
      logic [RootW-1:0] root;
   } cell_type;

endpackage

[rtl/vms_terms.sv]
// ----------------------------------------------------------------------------
// vms_terms: radicand formation
// Two registered stages: differences and squares, then the exact sum.
// ----------------------------------------------------------------------------
module vms_terms (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_vld,
   input  logic [1:0]                mode,
   input  logic signed [31:0]        normal_x,
   input  logic signed [31:0]        normal_y,
   input  logic signed [31:0]        normal_z,
   input  logic signed [31:0]        shear_xy,
   input  logic signed [31:0]        shear_yz,
   input  logic signed [31:0]        shear_zx,
   output logic                      out_vld,
   output logic [vms_pkg::RadW-1:0]  out_rad
);

   logic        s1_vld_ff, s1_vld_in;
   logic [65:0] sq_ff [0:5];
   logic [65:0] sq_in [0:5];
   logic        s2_vld_ff;
   logic [vms_pkg::RadW-1:0] rad_ff, rad_in;
   logic signed [32:0] d0, d1, d2;
   logic        plane, solid;

   function automatic logic [65:0] sqr(input logic signed [32:0] v);
      logic [32:0] m;
      m = v[32] ? 33'(-v) : v;
      return 66'(m * m);
   endfunction

   always_comb begin
      plane = (vms_pkg::mode_type'(mode) == vms_pkg::MODE_PLANE);
      solid = (vms_pkg::mode_type'(mode) == vms_pkg::MODE_SOLID);
      d0 = 33'(normal_x) - 33'(normal_y);
      d1 = solid ? 33'(normal_x) - 33'(normal_z) : 33'(normal_x);
      d2 = solid ? 33'(normal_z) - 33'(normal_y) : 33'(normal_y);
      sq_in[0] = (plane || solid) ? sqr(d0) : '0;
      sq_in[1] = (plane || solid) ? sqr(d1) : '0;
      sq_in[2] = (plane || solid) ? sqr(d2) : '0;
      sq_in[3] = (plane || solid) ? sqr(33'(shear_xy)) : '0;
      sq_in[4] = solid ? sqr(33'(shear_yz)) : '0;
      sq_in[5] = solid ? sqr(33'(shear_zx)) : '0;
      s1_vld_in = in_vld;
      // The normal sum is even, so halving it loses nothing.
      rad_in = (68'(sq_ff[0]) + 68'(sq_ff[1]) + 68'(sq_ff[2])) >> 1;
      rad_in = rad_in + 68'(sq_ff[3]) * 68'd3 + 68'(sq_ff[4]) * 68'd3
             + 68'(sq_ff[5]) * 68'd3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 6; i++) sq_ff[i] <= sq_in[i];
         rad_ff <= rad_in;
      end
   end

   assign out_vld = s2_vld_ff;
   assign out_rad = rad_ff;

endmodule

[rtl/vms_root_cell.sv]
// ----------------------------------------------------------------------------
// vms_root_cell: one bit of the restoring square root
// Tries the next root bit and hands remainder and root to its neighbor.
// ----------------------------------------------------------------------------
module vms_root_cell #(
   parameter int BIT = 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  vms_pkg::cell_type  prev,
   output vms_pkg::cell_type  next
);

   vms_pkg::cell_type cell_ff, cell_in;
   logic [vms_pkg::RadW-1:0] trial;

   always_comb begin
      // (2r + 2^b) * 2^b for the partial root r, which holds only higher bits.
      trial = (68'(prev.root) << (BIT + 1)) + (68'd1 << (2 * BIT));
      cell_in = prev;
      if (prev.rem >= trial) begin
         cell_in.rem = prev.rem - trial;
         cell_in.root[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cell_ff.vld <= 1'b0;
      else if (adv) cell_ff.vld <= cell_in.vld;
      if (adv) begin
         cell_ff.rem  <= cell_in.rem;
         cell_ff.rad  <= cell_in.rad;
         cell_ff.root <= cell_in.root;
      end
   end

   assign next = cell_ff;

endmodule

[rtl/von_mises_stress_core.sv]
// ----------------------------------------------------------------------------
// von_mises_stress_core: von Mises equivalent stress, one state per cycle unless the output stalls
// The radicand stages feed a row of 34 square-root cells, one root bit each.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | mode, six Q16.16 stress parts
// rsp     | out       | rsp_valid/rsp_stall | equivalent_stress, Q17.16
//
// One transaction is accepted every cycle while req_stall is low; a request
// passes the radicand stages, then one cell per root bit in the cell row.
// Reset is synchronous and clears only the valid bits in the pipeline.
// The pipeline advances as one piece whenever the output is empty or taken,
// so req_stall is high only while a result sits unclaimed at the end.
// ----------------------------------------------------------------------------
module von_mises_stress_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_normal_x,
   input  logic [31:0] req_normal_y,
   input  logic [31:0] req_normal_z,
   input  logic [31:0] req_shear_xy,
   input  logic [31:0] req_shear_yz,
   input  logic [31:0] req_shear_zx,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [32:0] rsp_equivalent_stress
);

   localparam int N = vms_pkg::RootW;

   logic adv;
   logic rad_vld;
   logic [vms_pkg::RadW-1:0] rad;
   vms_pkg::cell_type chain [0:N];

   // Every stage moves together; a taken or empty output frees the row.
   assign adv       = !(chain[N].vld && rsp_stall);
   assign req_stall = !adv;

   vms_terms u_terms (
      .clock, .reset, .adv,
      .in_vld   (req_valid),
      .mode     (req_mode),
      .normal_x (req_normal_x),
      .normal_y (req_normal_y),
      .normal_z (req_normal_z),
      .shear_xy (req_shear_xy),
      .shear_yz (req_shear_yz),
      .shear_zx (req_shear_zx),
      .out_vld  (rad_vld),
      .out_rad  (rad)
   );

   always_comb begin
      chain[0].vld  = rad_vld;
      chain[0].rem  = rad;
      chain[0].rad  = rad;
      chain[0].root = '0;
   end

   // The cell row: cell k decides root bit N-1-k.
   for (genvar k = 0; k < N; k++) begin : g_cell
      vms_root_cell #(.BIT(N - 1 - k)) u_cell (
         .clock, .reset, .adv,
         .prev (chain[k]),
         .next (chain[k + 1])
      );
   end

   assign rsp_valid             = chain[N].vld;
   assign rsp_equivalent_stress = chain[N].root[vms_pkg::OutW-1:0];

   // The finished root squared never exceeds its radicand.
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (68'(chain[N].root) * 68'(chain[N].root) <= chain[N].rad))
      else $error("root above radicand");
   // The next root up would exceed the radicand.
   a_root_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (chain[N].rem <= (68'(chain[N].root) << 1)))
      else $error("root below floor");
   // A stalled result holds while the row is frozen.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_equivalent_stress))
      else $error("result lost under stall");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking testbench for von_mises_stress_core
// Drives stress states through the request channel, predicts each von Mises
// result with an exact integer model, and compares every response in order.
// ----------------------------------------------------------------------------
module tb;

   // Test-local constants.
   localparam int RandItems  = 1400;
   localparam int QuietItems = 150;   // final stretch with no idling
   localparam int DrainWait  = 80;    // extra wait after the expectation queue empties

   // One request transaction as seen on the req_ ports.
   typedef struct packed {
      vms_pkg::mode_type mode;
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] sz;
      logic [31:0] txy;
      logic [31:0] tyz;
      logic [31:0] tzx;
   } stress_item_type;

   // A directed row: the stimulus, plus a typed-in expectation when known.
   typedef struct {
      stress_item_type item;
      logic            known;
      logic [32:0]     value;
   } stress_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [31:0] req_normal_x;
   logic [31:0] req_normal_y;
   logic [31:0] req_normal_z;
   logic [31:0] req_shear_xy;
   logic [31:0] req_shear_yz;
   logic [31:0] req_shear_zx;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [32:0] rsp_equivalent_stress;

   // Expected stress values, oldest first, filled when a request is accepted.
   logic [32:0] stress_expected[$];
   int          error_count;
   bit          stimulus_done;
   bit          quiet_phase;

   von_mises_stress_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_normal_x          (req_normal_x),
      .req_normal_y          (req_normal_y),
      .req_normal_z          (req_normal_z),
      .req_shear_xy          (req_shear_xy),
      .req_shear_yz          (req_shear_yz),
      .req_shear_zx          (req_shear_zx),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_equivalent_stress (rsp_equivalent_stress)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Square of the difference of two sign-extended components; always fits
   // in 66 bits because the difference is at most 2^32 in magnitude.
   function automatic logic [67:0] diff_square(logic [31:0] a, logic [31:0] b);
      logic signed [67:0] d;
      d = $signed({{36{a[31]}}, a}) - $signed({{36{b[31]}}, b});
      return d * d;
   endfunction

   // Exact von Mises radicand at twice the fraction bits, then a bitwise
   // floored square root over 34 root bits.
   function automatic logic [32:0] predict_stress(stress_item_type it);
      logic [67:0] radicand;
      logic [67:0] trial_sq;
      logic [33:0] root;
      logic [33:0] trial;
      radicand = '0;
      root     = '0;
      if (it.mode == vms_pkg::MODE_PLANE || it.mode == vms_pkg::MODE_SOLID) begin
         if (it.mode == vms_pkg::MODE_PLANE)
            radicand = diff_square(it.sx, it.sy) + diff_square(it.sx, 32'd0)
                     + diff_square(it.sy, 32'd0);
         else
            radicand = diff_square(it.sx, it.sy) + diff_square(it.sx, it.sz)
                     + diff_square(it.sz, it.sy);
         // The three squares always sum to an even number.
         radicand = (radicand >> 1) + 3 * diff_square(it.txy, 32'd0);
         if (it.mode == vms_pkg::MODE_SOLID)
            radicand = radicand + 3 * diff_square(it.tyz, 32'd0)
                     + 3 * diff_square(it.tzx, 32'd0);
         for (int b = 33; b >= 0; b--) begin
            trial    = root | (34'd1 << b);
            trial_sq = {34'd0, trial} * {34'd0, trial};
            if (trial_sq <= radicand) root = trial;
         end
      end
      return root[32:0];
   endfunction

   function automatic logic [31:0] rand_component();
      // Mix extremes, small magnitudes and full-range values.
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic stress_item_type rand_item();
      stress_item_type it;
      it.mode = vms_pkg::mode_type'(($urandom_range(0, 15) == 0)
                                    ? $urandom_range(0, 3) : $urandom_range(1, 2));
      it.sx  = rand_component();
      it.sy  = rand_component();
      it.sz  = rand_component();
      it.txy = rand_component();
      it.tyz = rand_component();
      it.tzx = rand_component();
      return it;
   endfunction

   function automatic stress_item_type make_item(vms_pkg::mode_type m, logic [31:0] x,
         logic [31:0] y, logic [31:0] z, logic [31:0] a, logic [31:0] b,
         logic [31:0] c);
      stress_item_type it;
      it = '{mode: m, sx: x, sy: y, sz: z, txy: a, tyz: b, tzx: c};
      return it;
   endfunction

   // Offers one transaction, waits until it is taken, then maybe idles.
   // The valid stays high from one item to the next unless the task idles.
   task automatic send_stress(stress_item_type it, logic known, logic [32:0] value);
      logic [32:0] predicted;
      predicted = predict_stress(it);
      if (known && predicted !== value) begin
         $display("%0t: table row mismatch expected %0d actual %0d",
                  $time, value, predicted);
         error_count++;
      end
      req_valid    <= 1'b1;
      req_mode     <= it.mode;
      req_normal_x <= it.sx;
      req_normal_y <= it.sy;
      req_normal_z <= it.sz;
      req_shear_xy <= it.txy;
      req_shear_yz <= it.tyz;
      req_shear_zx <= it.tzx;
      do @(posedge clock); while (req_stall);
      stress_expected.push_back(known ? value : predicted);
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   // Directed rows: extremes, every mode code, ignored components.
   stress_row_type directed_rows[] = '{
      '{make_item(vms_pkg::MODE_NONE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 1'b1, 33'd0},
      '{make_item(vms_pkg::MODE_RSVD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 1'b1, 33'd0},
      '{make_item(vms_pkg::MODE_PLANE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
        1'b1, 33'd0},
      '{make_item(vms_pkg::MODE_SOLID, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0),
        1'b1, 33'd0},
      // Uniaxial one: the result is exactly one.
      '{make_item(vms_pkg::MODE_PLANE, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h0), 1'b1, 33'h0_0001_0000},
      '{make_item(vms_pkg::MODE_SOLID, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h0), 1'b1, 33'h0_0001_0000},
      // Hydrostatic state gives zero in solid mode.
      '{make_item(vms_pkg::MODE_SOLID, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h0, 32'h0, 32'h0), 1'b1, 33'd0},
      // Plane mode ignores the out-of-plane components.
      '{make_item(vms_pkg::MODE_PLANE, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 32'h0,
                  32'h8000_0000, 32'h7FFF_FFFF), 1'b1, 33'h0_0001_0000},
      '{make_item(vms_pkg::MODE_PLANE, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
                  32'h0, 32'h0), 1'b1, 33'h0_8000_0000},
      '{make_item(vms_pkg::MODE_PLANE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                  32'h8000_0000, 32'h0, 32'h0), 1'b0, 33'd0},
      '{make_item(vms_pkg::MODE_SOLID, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, 33'd0},
      '{make_item(vms_pkg::MODE_SOLID, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, 33'd0},
      '{make_item(vms_pkg::MODE_SOLID, 32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000), 1'b0, 33'd0},
      '{make_item(vms_pkg::MODE_PLANE, 32'hFFFF_0000, 32'h0001_0000, 32'h0,
                  32'h0000_8000, 32'h0, 32'h0), 1'b0, 33'd0}
   };

   // Sender: reset, directed table, then random stress states.
   initial begin
      stress_item_type it;
      error_count   = 0;
      stimulus_done = 1'b0;
      quiet_phase   = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = vms_pkg::MODE_NONE;
      req_normal_x  = '0;
      req_normal_y  = '0;
      req_normal_z  = '0;
      req_shear_xy  = '0;
      req_shear_yz  = '0;
      req_shear_zx  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_stress(directed_rows[i].item, directed_rows[i].known,
                     directed_rows[i].value);
      for (int n = 0; n < RandItems; n++) begin
         if (n == RandItems - QuietItems) quiet_phase = 1'b1;
         it = rand_item();
         send_stress(it, 1'b0, 33'd0);
      end
      req_valid     <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Receiver stall: random bursts, one long hold-off early in the random
   // part so the pipeline fills and pushes back on the sender, and no
   // stalls at all during the final stretch. Every path leaves the stall
   // low when the loop ends.
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (200) @(negedge clock);
      rsp_stall <= 1'b1;
      repeat (120) @(negedge clock);
      rsp_stall <= 1'b0;
      while (!quiet_phase) begin
         @(negedge clock);
         if ($urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   // Response checker: compare each accepted result with the oldest
   // expectation.
   always @(posedge clock) begin
      logic [32:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (stress_expected.size() == 0) begin
            $display("%0t: unexpected result expected none actual %0d",
                     $time, rsp_equivalent_stress);
            error_count++;
         end else begin
            want = stress_expected.pop_front();
            if (rsp_equivalent_stress !== want) begin
               $display("%0t: equivalent_stress mismatch expected %0d actual %0d",
                        $time, want, rsp_equivalent_stress);
               error_count++;
            end
         end
      end
   end

   // End of run: drain, allow the latency again, then report once.
   initial begin
      wait (stimulus_done);
      while (stress_expected.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (error_count == 0)
         $display("PASS von_mises_stress_core");
      else
         $display("FAIL von_mises_stress_core");
      $finish;
   end

   // Watchdog, well beyond the slowest legal run.
   initial begin
      #400000;
      $display("FAIL von_mises_stress_core");
      $finish;
   end

endmodule
